// ----- design/etvad_pkg.sv -----
// ---------------------------------------------------------------------------
// etvad_pkg
// Types and constants shared by the energy threshold VAD segmenter.
// ---------------------------------------------------------------------------
package etvad_pkg;

    localparam int RES_CAP = 64;
    localparam int RES_W   = 7;

    localparam logic signed [31:0] E_MOST_POS = 32'sh7fff_ffff;
    localparam logic signed [31:0] E_MOST_NEG = 32'sh8000_0000;

    localparam logic [15:0] FRAC_RESET = 16'd6554;

    typedef struct packed {
        logic signed [31:0] frame_energy;
        logic        [31:0] frame_position;
        logic               last_frame;
    } t_in_item;

    typedef struct packed {
        logic [31:0] segment_start;
        logic [31:0] segment_end;
        logic        found;
        logic        last_segment;
        logic        overflowed;
    } t_out_item;

    typedef enum logic [3:0] {
        S_LOAD,
        S_MUL,
        S_ADD,
        S_SEEK_RD,
        S_SEEK_EV,
        S_DROP_RD,
        S_DROP_EV,
        S_END_RD,
        S_END_EV,
        S_FINISH
    } t_state;

endpackage

// ----- design/etvad_ram.sv -----
// ---------------------------------------------------------------------------
// etvad_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module etvad_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/energy_threshold_vad_segmenter_top.sv -----
// ---------------------------------------------------------------------------
// energy_threshold_vad_segmenter_top
// Stores frame energies and positions, forms a threshold from the running
// minimum and maximum, then scans the stored frames for voiced segments.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  in       | i_in_valid, o_in_stall | i_in_item  (t_in_item)
//  out      | o_out_valid, i_out_stall | o_out_item (t_out_item)
//  cfg      | i_cfg_we               | i_cfg_wdata (threshold fraction)
//
//  Frames load one per cycle while the running min/max update.
//  After the last frame the threshold is formed (one multiply, then one add),
//  then each scanned frame is read through the single RAM read port, each
//  segment end takes a further read; the run closes in S_FINISH, reached via
//  S_SEEK_RD when the scan runs past the last frame. Output stalls hold the run.
//  The input stalls from the last frame until the run closes.
//  Reset is synchronous, active low; RAM contents are not cleared.
// ---------------------------------------------------------------------------
module energy_threshold_vad_segmenter_top
    import etvad_pkg::*;
#(
    parameter int MAX_FRAMES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic signed [31:0] r_min, n_min;
    logic signed [31:0] r_max, n_max;
    logic               r_ovf, n_ovf;
    logic [15:0]        r_frac, n_frac;
    logic               r_out_vld, n_out_vld;
    logic               r_pend_vld, n_pend_vld;
    logic [RES_W-1:0]   r_nres, n_nres;

    logic [CW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_addr, n_addr;
    logic [48:0]        r_prod, n_prod;
    logic signed [31:0] r_thr, n_thr;
    logic [31:0]        r_start, n_start;
    logic               r_final, n_final;
    t_out_item          r_out, n_out;
    t_out_item          r_pend, n_pend;

    logic               w_we;
    logic [AW-1:0]      w_rd_addr;
    logic [63:0]        w_rdata;
    logic signed [31:0] w_ram_e;
    logic [31:0]        w_ram_p;
    logic               w_out_free;
    logic [CW-1:0]      w_last_idx;
    logic [32:0]        w_diff;
    logic [33:0]        w_thr_sum;

    etvad_ram #(
        .WIDTH (64),
        .DEPTH (MAX_FRAMES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in_item.frame_position, i_in_item.frame_energy}),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_ram_e    = w_rdata[31:0];
    assign w_ram_p    = w_rdata[63:32];
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_last_idx = r_count - 1'b1;
    assign w_diff     = {r_max[31], r_max} - {r_min[31], r_min};
    assign w_thr_sum  = {{2{r_min[31]}}, r_min} + {1'b0, r_prod[48:16]};

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_min      = r_min;
        n_max      = r_max;
        n_ovf      = r_ovf;
        n_frac     = r_frac;
        n_out_vld  = r_out_vld;
        n_pend_vld = r_pend_vld;
        n_nres     = r_nres;
        n_idx      = r_idx;
        n_addr     = r_addr;
        n_prod     = r_prod;
        n_thr      = r_thr;
        n_start    = r_start;
        n_final    = r_final;
        n_out      = r_out;
        n_pend     = r_pend;
        w_we       = 1'b0;
        w_rd_addr  = r_addr;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        if (i_cfg_we) begin
            n_frac = i_cfg_wdata;
        end

        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_count < CW'(MAX_FRAMES)) begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        if (i_in_item.frame_energy < r_min) begin
                            n_min = i_in_item.frame_energy;
                        end
                        if (i_in_item.frame_energy > r_max) begin
                            n_max = i_in_item.frame_energy;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_item.last_frame) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_prod  = 49'(w_diff) * 49'(r_frac);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_thr      = w_thr_sum[31:0];
                n_idx      = '0;
                n_nres     = '0;
                n_pend_vld = 1'b0;
                n_state    = S_SEEK_RD;
            end
            S_SEEK_RD: begin
                if (r_idx >= r_count) begin
                    n_state = S_FINISH;
                end else begin
                    w_rd_addr = r_idx[AW-1:0];
                    n_addr    = r_idx[AW-1:0];
                    n_state   = S_SEEK_EV;
                end
            end
            S_SEEK_EV: begin
                n_idx = r_idx + 1'b1;
                if (w_ram_e > r_thr) begin
                    n_start = w_ram_p;
                    n_state = S_DROP_RD;
                end else begin
                    n_state = S_SEEK_RD;
                end
            end
            S_DROP_RD: begin
                if (r_idx < w_last_idx) begin
                    w_rd_addr = r_idx[AW-1:0];
                    n_addr    = r_idx[AW-1:0];
                    n_state   = S_DROP_EV;
                end else begin
                    w_rd_addr = w_last_idx[AW-1:0];
                    n_addr    = w_last_idx[AW-1:0];
                    n_final   = 1'b1;
                    n_state   = S_END_EV;
                end
            end
            S_DROP_EV: begin
                n_idx = r_idx + 1'b1;
                if (w_ram_e < r_thr) begin
                    n_state = S_END_RD;
                end else begin
                    n_state = S_DROP_RD;
                end
            end
            S_END_RD: begin
                w_rd_addr = r_idx[AW-1:0];
                n_addr    = r_idx[AW-1:0];
                n_final   = 1'b0;
                n_state   = S_END_EV;
            end
            S_END_EV: begin
                if (!r_pend_vld || w_out_free) begin
                    if (r_pend_vld) begin
                        n_out     = r_pend;
                        n_out_vld = 1'b1;
                    end
                    n_pend.segment_start = r_start;
                    n_pend.segment_end   = w_ram_p;
                    n_pend.found         = 1'b1;
                    n_pend.last_segment  = 1'b0;
                    n_pend.overflowed    = r_ovf;
                    n_pend_vld           = 1'b1;
                    n_nres               = r_nres + 1'b1;
                    if (r_final || r_nres == RES_W'(RES_CAP - 1)) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SEEK_RD;
                    end
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    if (r_pend_vld) begin
                        n_out              = r_pend;
                        n_out.last_segment = 1'b1;
                    end else begin
                        n_out.segment_start = '0;
                        n_out.segment_end   = '0;
                        n_out.found         = 1'b0;
                        n_out.last_segment  = 1'b1;
                        n_out.overflowed    = r_ovf;
                    end
                    n_count    = '0;
                    n_min      = E_MOST_POS;
                    n_max      = E_MOST_NEG;
                    n_ovf      = 1'b0;
                    n_pend_vld = 1'b0;
                    n_nres     = '0;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_min      <= E_MOST_POS;
            r_max      <= E_MOST_NEG;
            r_ovf      <= 1'b0;
            r_frac     <= FRAC_RESET;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nres     <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_min      <= n_min;
            r_max      <= n_max;
            r_ovf      <= n_ovf;
            r_frac     <= n_frac;
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
            r_nres     <= n_nres;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_addr  <= n_addr;
        r_prod  <= n_prod;
        r_thr   <= n_thr;
        r_start <= n_start;
        r_final <= n_final;
        r_out   <= n_out;
        r_pend  <= n_pend;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FRAMES))
        else $error("frame count beyond store depth");

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= RES_W'(RES_CAP))
        else $error("result count beyond cap");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> o_out_item.last_segment)
        else $error("empty result not marked last");

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_FINISH && r_state == S_LOAD) |->
            (r_count == '0 && !r_ovf && !r_pend_vld))
        else $error("run state not cleared after finish");

endmodule
